>>> rtl/ial_pkg.sv
// Package for the indexed array list engine.
// Holds sizes, command codes and the cell control struct; no dependencies.
package ial_pkg;

	localparam int CAPACITY  = 256;
	localparam int ELEM_W    = 32;
	localparam int CMD_W     = 3;
	localparam int IDX_W     = 9;
	localparam int VAL_W     = 32;
	localparam int CNT_W     = 9;
	localparam int LEN_W     = $clog2(CAPACITY + 1);
	// width wide enough for both list lengths and request indexes
	localparam int CMP_W     = (LEN_W > IDX_W) ? LEN_W : IDX_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_GET    = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_DELETE = 3'd2,
		CMD_LOCATE = 3'd3,
		CMD_CLEAR  = 3'd4
	} ial_cmd_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL
	} ial_cell_op_t;

	// broadcast to every cell in the execute cycle
	typedef struct packed {
		logic              en;
		ial_cell_op_t      op;
		logic [CMP_W-1:0]  target;  // 0-based slot addressed by the command
		logic [CMP_W-1:0]  len;     // list length before the command
		logic [ELEM_W-1:0] key;     // insert value or locate key
	} ial_ctrl_t;

endpackage

>>> rtl/ial_cell.sv
// One slot of the list: holds an entry, shifts with its neighbours,
// compares against the key. Depends on ial_pkg.
module ial_cell import ial_pkg::*; (
	input  logic              clk,
	input  ial_ctrl_t         ctrl,
	input  logic [CMP_W-1:0]  slot,
	input  logic [ELEM_W-1:0] left,
	input  logic [ELEM_W-1:0] right,
	output logic [ELEM_W-1:0] data,
	output logic              hit,
	output logic [ELEM_W-1:0] pick
);

	logic [ELEM_W-1:0] data_q;
	logic              hit_q;
	logic [ELEM_W-1:0] pick_q;

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			// pick and hit sample the entry before any shift
			hit_q  <= (data_q == ctrl.key) && (slot < ctrl.len);
			pick_q <= (slot == ctrl.target) ? data_q : '0;
			case (ctrl.op)
				CELL_INS: begin
					if (slot == ctrl.target)
						data_q <= ctrl.key;
					else if (slot > ctrl.target)
						data_q <= left;
				end
				CELL_DEL: begin
					if (slot >= ctrl.target)
						data_q <= right;
				end
				default: ;
			endcase
		end
	end

	assign data = data_q;
	assign hit  = hit_q;
	assign pick = pick_q;

endmodule

>>> rtl/ial_reduce.sv
// Collects the per-cell results: OR of picked entries and the first hit.
// Depends on ial_pkg.
module ial_reduce import ial_pkg::*; (
	input  logic [CAPACITY-1:0]             hits,
	input  logic [CAPACITY-1:0][ELEM_W-1:0] picks,
	output logic [CMP_W-1:0]                found,
	output logic [ELEM_W-1:0]               picked
);

	// at most one cell picks, so an OR gives its entry
	always_comb begin
		picked = '0;
		for (int i = 0; i < CAPACITY; i++)
			picked = picked | picks[i];
	end

	// 1-based position of the lowest hit, 0 when none
	always_comb begin
		found = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (hits[i])
				found = CMP_W'(i + 1);
		end
	end

endmodule

>>> rtl/indexed_array_list_engine.sv
// Top level of the indexed array list engine: command decode, length
// register, the row of list cells and the result registers.
// Depends on ial_pkg, ial_cell and ial_reduce.
//
//  channel   handshake            fields
//  --------  -------------------  ---------------------------------------
//  command   start && !busy       cmd, index, value
//  result    done (one cycle)     status, value_out, position, count,
//                                 is_empty
//
// A command passes through an execute cycle, in which every cell
// shifts and compares at once, then a reduce cycle that reduces the cell
// flags to the picked entry and the first match. busy is high only in
// the execute cycle, so a new command may be taken in this one's reduce cycle.
// The result beat appears the cycle after the reduce cycle, for one
// cycle; the receiver cannot stall it. Reset clears the length and the
// control flags; the entries themselves hold junk until written.
module indexed_array_list_engine import ial_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [CMD_W-1:0] cmd,
	input  logic [IDX_W-1:0] index,
	input  logic [VAL_W-1:0] value,
	output logic             done,
	output logic             status,
	output logic [VAL_W-1:0] value_out,
	output logic [IDX_W-1:0] position,
	output logic [CNT_W-1:0] count,
	output logic             is_empty
);

	// stage flags
	logic exec_q;   // execute cycle
	logic red_q;    // reduce cycle
	logic done_q;   // result beat on the ports

	// captured command beat
	ial_cmd_t         cmd_s1;
	logic [IDX_W-1:0] index_s1;
	logic [VAL_W-1:0] value_s1;

	// list length
	logic [LEN_W-1:0] len_q;

	// carried into the reduce cycle
	ial_cmd_t         cmd_s2;
	logic             err_s2;
	logic [LEN_W-1:0] len_s2;

	// result registers
	logic             status_q;
	logic [VAL_W-1:0] value_out_q;
	logic [IDX_W-1:0] position_q;
	logic [CNT_W-1:0] count_q;
	logic             is_empty_q;

	logic             accept;
	logic [CMP_W-1:0] idx_c;
	logic [CMP_W-1:0] len_c;
	logic             err_c;
	logic [LEN_W-1:0] len_next;
	ial_ctrl_t        ctrl;

	logic [CAPACITY-1:0][ELEM_W-1:0] cell_data;
	logic [CAPACITY-1:0]             cell_hit;
	logic [CAPACITY-1:0][ELEM_W-1:0] cell_pick;
	logic [CMP_W-1:0]                found;
	logic [ELEM_W-1:0]               picked;

	assign busy   = exec_q;
	assign accept = start && !exec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exec_q <= 1'b0;
			red_q  <= 1'b0;
			done_q <= 1'b0;
			len_q  <= '0;
		end else begin
			exec_q <= accept;
			red_q  <= exec_q;
			done_q <= red_q;
			if (exec_q)
				len_q <= len_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= ial_cmd_t'(cmd);
			index_s1 <= index;
			value_s1 <= value;
		end
		if (exec_q) begin
			cmd_s2 <= cmd_s1;
			err_s2 <= err_c;
			len_s2 <= len_next;
		end
	end

	// execute-cycle decode: range checks, new length and cell command
	always_comb begin
		idx_c       = CMP_W'(index_s1);
		len_c       = CMP_W'(len_q);
		err_c       = 1'b0;
		len_next    = len_q;
		ctrl.en     = exec_q;
		ctrl.op     = CELL_HOLD;
		ctrl.target = idx_c - CMP_W'(1);
		ctrl.len    = len_c;
		ctrl.key    = ELEM_W'(value_s1);
		case (cmd_s1)
			CMD_GET: begin
				err_c = (idx_c == '0) || (idx_c > len_c);
			end
			CMD_INSERT: begin
				err_c = (idx_c == '0) || (idx_c > len_c + CMP_W'(1))
					|| (len_c >= CMP_W'(CAPACITY));
				if (!err_c) begin
					ctrl.op  = CELL_INS;
					len_next = len_q + LEN_W'(1);
				end
			end
			CMD_DELETE: begin
				err_c = (idx_c == '0) || (idx_c > len_c);
				if (!err_c) begin
					ctrl.op  = CELL_DEL;
					len_next = len_q - LEN_W'(1);
				end
			end
			CMD_LOCATE: ;
			CMD_CLEAR: begin
				len_next = '0;
			end
			default: begin
				err_c = 1'b1;
			end
		endcase
	end

	// the row of cells; each takes from its lower neighbour on insert and
	// from its upper neighbour on delete
	for (genvar p = 0; p < CAPACITY; p++) begin : g_cell
		logic [ELEM_W-1:0] left;
		logic [ELEM_W-1:0] right;

		if (p == 0) begin : g_first
			assign left = '0;
		end else begin : g_left
			assign left = cell_data[p-1];
		end
		if (p == CAPACITY - 1) begin : g_last
			assign right = '0;
		end else begin : g_right
			assign right = cell_data[p+1];
		end

		ial_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.slot  (CMP_W'(p)),
			.left  (left),
			.right (right),
			.data  (cell_data[p]),
			.hit   (cell_hit[p]),
			.pick  (cell_pick[p])
		);
	end

	ial_reduce u_reduce (
		.hits   (cell_hit),
		.picks  (cell_pick),
		.found  (found),
		.picked (picked)
	);

	// reduce cycle: form the result beat
	always_ff @(posedge clk) begin
		if (red_q) begin
			status_q    <= err_s2;
			value_out_q <= (!err_s2 && (cmd_s2 == CMD_GET || cmd_s2 == CMD_DELETE))
				? VAL_W'(picked) : '0;
			position_q  <= (!err_s2 && cmd_s2 == CMD_LOCATE) ? IDX_W'(found) : '0;
			count_q     <= CNT_W'(len_s2);
			is_empty_q  <= (len_s2 == '0);
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign value_out = value_out_q;
	assign position  = position_q;
	assign count     = count_q;
	assign is_empty  = is_empty_q;

endmodule
